// ===== hdl/device_id_string_validator_macros.svh =====
// Assertion helpers for the identifier validator.
`ifndef DEVICE_ID_STRING_VALIDATOR_MACROS_SVH
`define DEVICE_ID_STRING_VALIDATOR_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define IDV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("idv assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define IDV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("idv assertion failed");

`endif

// ===== hdl/idv_pkg.sv =====
`default_nettype none
package idv_pkg;

    localparam int SERIAL_MAX_LEN_DEF = 32;

    localparam int CNT_W   = 6;
    localparam int LUHN_W  = 4;
    localparam int CODE_W  = 16;
    localparam int DIGIT_W = 4;
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [KIND_W-1:0] KIND_SERIAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAC    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IMEI   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ID_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMEI_MODE = 2'd1;

    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd0;

    localparam logic [CNT_W-1:0] MAC_LEN    = 6'd12;
    localparam logic [CNT_W-1:0] IMEI_SHORT = 6'd14;
    localparam logic [CNT_W-1:0] IMEI_LONG  = 6'd15;

    localparam logic [CODE_W-1:0] CODE_ZERO  = 16'h0030;
    localparam logic [CODE_W-1:0] CODE_NINE  = 16'h0039;
    localparam logic [CODE_W-1:0] CODE_UA    = 16'h0041;
    localparam logic [CODE_W-1:0] CODE_UF    = 16'h0046;
    localparam logic [CODE_W-1:0] CODE_LA    = 16'h0061;
    localparam logic [CODE_W-1:0] CODE_LF    = 16'h0066;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [LUHN_W-1:0] luhn;
        logic              only_dec;
        logic              only_hex;
    } t_acc;

    typedef struct packed {
        logic               id_valid;
        logic [DIGIT_W-1:0] check_digit;
    } t_result;

    function automatic logic is_dec(input logic [CODE_W-1:0] c);
        return (c >= CODE_ZERO) && (c <= CODE_NINE);
    endfunction

    function automatic logic is_hex(input logic [CODE_W-1:0] c);
        return is_dec(c) || ((c >= CODE_UA) && (c <= CODE_UF))
            || ((c >= CODE_LA) && (c <= CODE_LF));
    endfunction

    // Add one digit (doubled and folded when dbl) to a mod-10 sum.
    function automatic logic [LUHN_W-1:0] luhn_add(input logic [LUHN_W-1:0] sum,
                                                   input logic [DIGIT_W-1:0] d,
                                                   input logic dbl);
        logic [4:0] t;
        logic [4:0] s;
        t = dbl ? {d, 1'b0} : {1'b0, d};
        if (t >= 5'd10) begin
            t = t - 5'd9;
        end
        s = {1'b0, sum} + t;
        if (s >= 5'd10) begin
            s = s - 5'd10;
        end
        return s[LUHN_W-1:0];
    endfunction

    function automatic logic [DIGIT_W-1:0] luhn_check(input logic [LUHN_W-1:0] sum);
        return (sum == '0) ? '0 : (DIGIT_W'(10) - sum);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/idv_accum.sv =====
`default_nettype none
module idv_accum #(
    parameter int SERIAL_MAX_LEN = idv_pkg::SERIAL_MAX_LEN_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [idv_pkg::CODE_W-1:0] i_char_code,
    input  wire logic                       i_last_char,
    output idv_pkg::t_acc                   o_next
);
    import idv_pkg::*;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(SERIAL_MAX_LEN + 1);

    t_acc r_acc;
    t_acc n_acc;
    logic dec;

    assign dec = is_dec(i_char_code);

    always_comb begin
        n_acc = r_acc;
        if ((r_acc.count < IMEI_SHORT) && dec) begin
            n_acc.luhn = luhn_add(r_acc.luhn, i_char_code[DIGIT_W-1:0], r_acc.count[0]);
        end
        if (!dec) begin
            n_acc.only_dec = 1'b0;
        end
        if (!is_hex(i_char_code)) begin
            n_acc.only_hex = 1'b0;
        end
        if (r_acc.count < CAP) begin
            n_acc.count = r_acc.count + 1'b1;
        end
    end

    assign o_next = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '{count: '0, luhn: '0, only_dec: 1'b1, only_hex: 1'b1};
        end else if (i_step) begin
            if (i_last_char) begin
                r_acc <= '{count: '0, luhn: '0, only_dec: 1'b1, only_hex: 1'b1};
            end else begin
                r_acc <= n_acc;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/idv_verdict.sv =====
`default_nettype none
module idv_verdict #(
    parameter int SERIAL_MAX_LEN = idv_pkg::SERIAL_MAX_LEN_DEF
) (
    input  wire idv_pkg::t_acc              i_acc,
    input  wire logic [idv_pkg::CODE_W-1:0] i_char_code,
    input  wire logic [idv_pkg::KIND_W-1:0] i_id_kind,
    input  wire logic [idv_pkg::MODE_W-1:0] i_imei_mode,
    output idv_pkg::t_result                o_result
);
    import idv_pkg::*;

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(SERIAL_MAX_LEN);

    logic [DIGIT_W-1:0] chk;
    logic               allow14;
    logic               allow15;
    logic               digits_14_15;

    assign chk          = luhn_check(i_acc.luhn);
    assign allow14      = (i_imei_mode == MODE_BOTH) || i_imei_mode[0];
    assign allow15      = (i_imei_mode == MODE_BOTH) || i_imei_mode[1];
    assign digits_14_15 = (i_acc.count == IMEI_SHORT) || (i_acc.count == IMEI_LONG);

    always_comb begin
        o_result = '{id_valid: 1'b0, check_digit: '0};
        unique case (i_id_kind)
            KIND_SERIAL: begin
                o_result.id_valid = (i_acc.count != '0) && (i_acc.count <= MAX_LEN);
            end
            KIND_MAC: begin
                o_result.id_valid = (i_acc.count == MAC_LEN) && i_acc.only_hex;
            end
            KIND_IMEI: begin
                priority if (allow15 && (i_acc.count == IMEI_LONG)) begin
                    o_result.id_valid = i_acc.only_dec
                        && (i_char_code == (CODE_ZERO + CODE_W'(chk)));
                end else if (allow14 && (i_acc.count == IMEI_SHORT)) begin
                    o_result.id_valid = i_acc.only_dec;
                end else begin
                    o_result.id_valid = 1'b0;
                end
                if (i_acc.only_dec && digits_14_15) begin
                    o_result.check_digit = chk;
                end
            end
            default: begin
                o_result = '{id_valid: 1'b0, check_digit: '0};
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/device_id_string_validator.sv =====
// Identifier string validator (serial number, MAC address, IMEI with Luhn check).
// Throughput: one character per cycle, back to back, unless a closing character waits on a held result.
// The input register loads at the accepting edge; the result register loads from it when
// the closing character advances, after which the result is valid.
// Reset (synchronous, active low) clears string state, configuration and valids.
`default_nettype none
module device_id_string_validator #(
    parameter int SERIAL_MAX_LEN = idv_pkg::SERIAL_MAX_LEN_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output wire logic                           o_in_ready,
    input  wire logic [idv_pkg::CODE_W-1:0]     i_char_code,
    input  wire logic                           i_last_char,
    output wire logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output wire logic                           o_id_valid,
    output wire logic [idv_pkg::DIGIT_W-1:0]    o_check_digit,
    input  wire logic                           i_cfg_valid,
    output wire logic                           o_cfg_ready,
    input  wire logic [idv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [idv_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import idv_pkg::*;

    logic               r_s1_valid;
    logic [CODE_W-1:0]  r_s1_code;
    logic               r_s1_last;
    logic               r_out_valid;
    t_result            r_out;
    logic [KIND_W-1:0]  r_id_kind;
    logic [MODE_W-1:0]  r_imei_mode;

    logic    s1_advance;
    logic    in_accept;
    t_acc    acc_next;
    t_result result;

    assign s1_advance = r_s1_valid && (!r_s1_last || !r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;

    assign o_in_ready    = !r_s1_valid || s1_advance;
    assign o_out_valid   = r_out_valid;
    assign o_id_valid    = r_out.id_valid;
    assign o_check_digit = r_out.check_digit;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_kind   <= KIND_SERIAL;
            r_imei_mode <= MODE_BOTH;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ID_KIND) begin
                r_id_kind <= i_cfg_data;
            end else if (i_cfg_index == REG_IMEI_MODE) begin
                r_imei_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_code <= i_char_code;
            r_s1_last <= i_last_char;
        end
    end

    idv_accum #(
        .SERIAL_MAX_LEN(SERIAL_MAX_LEN)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_advance),
        .i_char_code (r_s1_code),
        .i_last_char (r_s1_last),
        .o_next      (acc_next)
    );

    idv_verdict #(
        .SERIAL_MAX_LEN(SERIAL_MAX_LEN)
    ) u_verdict (
        .i_acc       (acc_next),
        .i_char_code (r_s1_code),
        .i_id_kind   (r_id_kind),
        .i_imei_mode (r_imei_mode),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_last) begin
            r_out <= result;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/idv_checker.sv =====
`default_nettype none
`include "device_id_string_validator_macros.svh"
module idv_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        i_last_char,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic                        o_id_valid,
    input wire logic [idv_pkg::DIGIT_W-1:0] o_check_digit
);
    import idv_pkg::*;

    `IDV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_id_valid) && $stable(o_check_digit))

    `IDV_ASSERT_IMPLY(a_digit_range, i_clk, i_rst_n, o_out_valid,
        o_check_digit <= DIGIT_W'(9))

    `IDV_ASSERT_IMPLY(a_result_from_last, i_clk, i_rst_n, $rose(o_out_valid),
        $past(i_in_valid && o_in_ready && i_last_char, 2))

endmodule

bind device_id_string_validator idv_checker u_idv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_last_char   (i_last_char),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_id_valid    (o_id_valid),
    .o_check_digit (o_check_digit)
);
`default_nettype wire

// ===== dv/device_id_string_validator_tb.sv =====
`timescale 1ns / 100ps
module device_id_string_validator_tb;
    import idv_pkg::*;

    localparam int SERIAL_MAX   = SERIAL_MAX_LEN_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [KIND_W-1:0]    KIND_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_ONLY14  = 2'd1;
    localparam logic [MODE_W-1:0]    MODE_ONLY15  = 2'd2;
    localparam logic [MODE_W-1:0]    MODE_EITHER  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int IMEI_GOOD     = 0;
    localparam int IMEI_BADCHECK = 1;
    localparam int IMEI_NONDIGIT = 2;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_char_req;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid  = 1'b0;
    logic [CODE_W-1:0]     i_char_code = '0;
    logic                  i_last_char = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    wire                   o_in_ready;
    wire                   o_out_valid;
    wire                   o_id_valid;
    wire [DIGIT_W-1:0]     o_check_digit;
    wire                   o_cfg_ready;

    t_char_req char_q[$];
    t_result   verdict_q[$];
    t_char_req next_req;
    t_result   want;

    // mirror of the block's registers and string accumulator
    logic [KIND_W-1:0] cfg_kind = KIND_SERIAL;
    logic [MODE_W-1:0] cfg_mode = MODE_BOTH;
    int acc_len = 0;
    int acc_sum = 0;
    bit acc_dec = 1'b1;
    bit acc_hex = 1'b1;

    bit in_taken   = 1'b0;
    bit cfg_taken  = 1'b0;
    bit out_taken  = 1'b0;
    bit idle_on    = 1'b0;
    bit hold_go    = 1'b0;
    bit hold_done  = 1'b0;
    int hold_left  = 0;
    int send_gap   = 0;
    int take_gap   = 0;
    int stall_cycles = 0;

    int items_made   = 0;
    int chars_taken  = 0;
    int strings_seen = 0;
    int valid_seen   = 0;
    int mismatches   = 0;
    int phases       = 0;

    device_id_string_validator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_code   (i_char_code),
        .i_last_char   (i_last_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_id_valid    (o_id_valid),
        .o_check_digit (o_check_digit),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic bit dec_code(input logic [CODE_W-1:0] c);
        return c >= CODE_ZERO && c <= CODE_NINE;
    endfunction

    function automatic bit hex_code(input logic [CODE_W-1:0] c);
        return dec_code(c) || (c >= CODE_UA && c <= CODE_UF) || (c >= CODE_LA && c <= CODE_LF);
    endfunction

    function automatic int fold_digit(input int d, input bit twice);
        int v;
        v = twice ? 2 * d : d;
        return (v >= 10) ? v - 9 : v;
    endfunction

    // per-character update; closing character yields the verdict
    task automatic absorb_char(input logic [CODE_W-1:0] code, input logic last);
        t_result r;
        int chk;
        bit allow14;
        bit allow15;
        if (acc_len < IMEI_SHORT && dec_code(code)) begin
            acc_sum = (acc_sum + fold_digit(int'(code - CODE_ZERO), acc_len % 2 == 1)) % 10;
        end
        if (!dec_code(code)) acc_dec = 1'b0;
        if (!hex_code(code)) acc_hex = 1'b0;
        if (acc_len < SERIAL_MAX + 1) acc_len++;
        if (last) begin
            r = '0;
            chk = (10 - acc_sum) % 10;
            case (cfg_kind)
                KIND_SERIAL: r.id_valid = acc_len >= 1 && acc_len <= SERIAL_MAX;
                KIND_MAC:    r.id_valid = acc_len == MAC_LEN && acc_hex;
                KIND_IMEI: begin
                    allow14 = cfg_mode == MODE_BOTH || (cfg_mode & MODE_ONLY14) != '0;
                    allow15 = cfg_mode == MODE_BOTH || (cfg_mode & MODE_ONLY15) != '0;
                    if (allow15 && acc_len == IMEI_LONG) begin
                        r.id_valid = acc_dec && code == CODE_ZERO + chk;
                    end else if (allow14 && acc_len == IMEI_SHORT) begin
                        r.id_valid = acc_dec;
                    end
                    if (acc_dec && (acc_len == IMEI_SHORT || acc_len == IMEI_LONG)) begin
                        r.check_digit = chk[DIGIT_W-1:0];
                    end
                end
                default: ;
            endcase
            verdict_q.push_back(r);
            acc_len = 0;
            acc_sum = 0;
            acc_dec = 1'b1;
            acc_hex = 1'b1;
        end
    endtask

    function automatic logic [CODE_W-1:0] rand_code();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CODE_W'(CODE_ZERO + $urandom_range(0, 9));
            4: return CODE_W'(CODE_UA + $urandom_range(0, 5));
            5: return CODE_W'(CODE_LA + $urandom_range(0, 5));
            6: begin
                case ($urandom_range(0, 7))
                    0: return CODE_W'(CODE_ZERO - 1);
                    1: return CODE_W'(CODE_NINE + 1);
                    2: return CODE_W'(CODE_UA - 1);
                    3: return CODE_W'(CODE_UF + 1);
                    4: return CODE_W'(CODE_LA - 1);
                    5: return CODE_W'(CODE_LF + 1);
                    6: return '0;
                    default: return '1;
                endcase
            end
            default: return CODE_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] rand_hex();
        case ($urandom_range(0, 2))
            0: return CODE_W'(CODE_ZERO + $urandom_range(0, 9));
            1: return CODE_W'(CODE_UA + $urandom_range(0, 5));
            default: return CODE_W'(CODE_LA + $urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] rand_outside(input bit hex_too);
        logic [CODE_W-1:0] c;
        do c = rand_code(); while (hex_too ? hex_code(c) : dec_code(c));
        return c;
    endfunction

    task automatic push_char(input logic [CODE_W-1:0] code, input logic last);
        t_char_req r;
        r.code = code;
        r.last = last;
        char_q.push_back(r);
        items_made++;
    endtask

    task automatic push_any(input int len);
        int k;
        for (k = 0; k < len; k++) push_char(rand_code(), k == len - 1);
    endtask

    task automatic push_mac(input int len, input bit spoil);
        int k;
        int bad;
        bad = spoil ? $urandom_range(0, len - 1) : -1;
        for (k = 0; k < len; k++) begin
            push_char((k == bad) ? rand_outside(1'b1) : rand_hex(), k == len - 1);
        end
    endtask

    task automatic push_imei(input int len, input int flavor);
        int k;
        int d;
        int sum;
        int bad;
        bad = (flavor == IMEI_NONDIGIT) ? $urandom_range(0, len - 1) : -1;
        sum = 0;
        for (k = 0; k < len; k++) begin
            d = $urandom_range(0, 9);
            if (k < IMEI_SHORT) begin
                sum = (sum + fold_digit(d, k % 2 == 1)) % 10;
            end else if (k == IMEI_LONG - 1) begin
                d = (10 - sum) % 10;
                if (flavor == IMEI_BADCHECK) d = (d + $urandom_range(1, 9)) % 10;
            end
            push_char((k == bad) ? rand_outside(1'b0) : CODE_W'(CODE_ZERO + d),
                      k == len - 1);
        end
    endtask

    // mostly strings shaped for the active kind, some noise and overlong ones
    task automatic gen_string(input logic [KIND_W-1:0] kind);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
            push_any($urandom_range(SERIAL_MAX - 1, SERIAL_MAX + 8));
        end else if (kind == KIND_IMEI && pick < 7) begin
            case (pick)
                3: push_imei(IMEI_LONG, IMEI_BADCHECK);
                4: push_imei($urandom_range(IMEI_SHORT, IMEI_LONG), IMEI_NONDIGIT);
                5, 6: push_imei($urandom_range(IMEI_SHORT - 2, IMEI_LONG + 2), IMEI_GOOD);
                default: push_imei($urandom_range(IMEI_SHORT, IMEI_LONG), IMEI_GOOD);
            endcase
        end else if (kind == KIND_MAC && pick < 7) begin
            push_mac(pick < 5 ? MAC_LEN : $urandom_range(MAC_LEN - 2, MAC_LEN + 2),
                     pick == 4 || pick == 6);
        end else begin
            case ($urandom_range(0, 2))
                0: push_any($urandom_range(1, 16));
                1: push_mac(MAC_LEN, 1'b0);
                default: push_imei(IMEI_LONG, IMEI_GOOD);
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (chars_taken != items_made || verdict_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [KIND_W-1:0] kind, input logic [MODE_W-1:0] mode,
                             input int n, input bit idle);
        int stop;
        wait_idle();
        write_reg(REG_ID_KIND, kind);
        write_reg(REG_IMEI_MODE, mode);
        idle_on = idle;
        stop = items_made + n;
        while (items_made < stop) gen_string(kind);
        phases++;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (char_q.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
                send_gap   <= $urandom_range(0, 11);
                i_in_valid <= 1'b0;
            end else if (char_q.size() != 0) begin
                next_req = char_q.pop_front();
                i_in_valid  <= 1'b1;
                i_char_code <= next_req.code;
                i_last_char <= next_req.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap    <= take_gap - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            take_gap    <= $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge i_clk) begin
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        cfg_taken = i_rst_n && i_cfg_valid && o_cfg_ready;
        out_taken = i_rst_n && o_out_valid && i_out_ready;
        if (cfg_taken) begin
            if (i_cfg_index == REG_ID_KIND) begin
                cfg_kind = i_cfg_data;
            end else if (i_cfg_index == REG_IMEI_MODE) begin
                cfg_mode = i_cfg_data;
            end
        end
        if (in_taken) begin
            chars_taken++;
            absorb_char(i_char_code, i_last_char);
        end
        if (out_taken) begin
            strings_seen++;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: id_valid=%0b check_digit=%0d",
                             o_id_valid, o_check_digit);
                end
            end else begin
                want = verdict_q.pop_front();
                if (want.id_valid) valid_seen++;
                if (o_id_valid !== want.id_valid || o_check_digit !== want.check_digit) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch on string %0d: expected id_valid=%0b check_digit=%0d,"
                                 , strings_seen, want.id_valid, want.check_digit,
                                 " got id_valid=%0b check_digit=%0d", o_id_valid, o_check_digit);
                    end
                end
            end
        end
        if (!i_rst_n || in_taken || cfg_taken || out_taken) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
                $display("** device_id_string_validator: FAILED **");
                $finish;
            end
        end
    end

    initial begin : main
        int k;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: code extremes, character class edges, edges of the hex alphabet
        write_reg(REG_ID_KIND, KIND_SERIAL);
        write_reg(REG_IMEI_MODE, MODE_BOTH);
        idle_on = 1'b1;
        push_char('0, 1'b1);
        push_char('1, 1'b1);
        push_char(CODE_W'(CODE_ZERO - 1), 1'b0);
        push_char(CODE_W'(CODE_NINE + 1), 1'b1);
        wait_idle();
        write_reg(REG_ID_KIND, KIND_MAC);
        for (k = 0; k < MAC_LEN; k++) begin
            case (k % 6)
                0: push_char(CODE_ZERO, 1'b0);
                1: push_char(CODE_NINE, 1'b0);
                2: push_char(CODE_UA, 1'b0);
                3: push_char(CODE_UF, 1'b0);
                4: push_char(CODE_LA, 1'b0);
                default: push_char(CODE_LF, k == MAC_LEN - 1);
            endcase
        end
        wait_idle();
        // write to a nonexistent register must leave the kind alone
        write_reg(REG_UNMAPPED, '1);
        push_char(CODE_UA, 1'b1);
        wait_idle();
        write_reg(REG_ID_KIND, KIND_UNUSED);
        push_any(3);
        phases++;

        // output held off while single-character strings keep coming
        wait_idle();
        write_reg(REG_ID_KIND, KIND_SERIAL);
        idle_on = 1'b0;
        hold_go = 1'b1;
        repeat (40) push_char(rand_code(), 1'b1);
        phases++;

        run_phase(KIND_IMEI, MODE_BOTH, 60, 1'b1);
        run_phase(KIND_IMEI, MODE_ONLY14, 45, 1'b1);
        run_phase(KIND_IMEI, MODE_ONLY15, 45, 1'b0);
        run_phase(KIND_IMEI, MODE_EITHER, 45, 1'b1);
        run_phase(KIND_MAC, MODE_EITHER, 45, 1'b1);
        run_phase(KIND_SERIAL, MODE_ONLY15, 45, 1'b1);
        run_phase(KIND_UNUSED, MODE_BOTH, 30, 1'b1);
        while (items_made < 540) begin
            run_phase(KIND_W'($urandom_range(0, 3)), MODE_W'($urandom_range(0, 3)), 50,
                      $urandom_range(0, 3) != 0);
        end
        run_phase(KIND_IMEI, MODE_BOTH, 60, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d characters in %0d strings across %0d register settings, %0d judged valid",
                 chars_taken, strings_seen, phases, valid_seen);
        $display("covered serial, MAC, IMEI and unused kinds, all length modes, long strings,",
                 " bad check digits and a %0d-cycle output hold", HOLD_CYCLES);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("** device_id_string_validator: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, verdict_q.size());
            $display("** device_id_string_validator: FAILED **");
        end
        $finish;
    end

endmodule
